@@ src/rfrt_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfrt_pkg
// Shared types, codes and constants of the fragment reassembly tracker.
// ---------------------------------------------------------------------------
package rfrt_pkg;

  localparam int DefFragmentSlots = 16;
  localparam int DefPayloadBytes  = 32;
  localparam int HdrBytes         = 11;
  localparam int IdByte           = 9;
  localparam logic [7:0] IdMask   = 8'b0111_1111;
  localparam logic [7:0] FinalBit = 8'b1000_0000;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_BYTE   = 2'd1;
  localparam logic [1:0] FUNC_VERIFY = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_RESEND_ALL  = 4'd1;
  localparam logic [3:0] ST_ALL_TIMEOUT = 4'd2;
  localparam logic [3:0] ST_RETRANSMIT  = 4'd3;
  localparam logic [3:0] ST_RT_TIMEOUT  = 4'd4;
  localparam logic [3:0] ST_ACCEPTED    = 4'd5;
  localparam logic [3:0] ST_SHORT       = 4'd6;
  localparam logic [3:0] ST_LONG        = 4'd7;
  localparam logic [3:0] ST_ID_ZERO     = 4'd8;
  localparam logic [3:0] ST_ID_LARGE    = 4'd9;
  localparam logic [3:0] ST_ACK         = 4'd10;

  localparam logic REG_MAX_RESEND     = 1'b0;
  localparam logic REG_MAX_RETRANSMIT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COPY,
    S_SCAN,
    S_READ,
    S_OUT
  } rfrt_state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;        // capture input item
    logic stage_byte;  // write staged byte
    logic end_start;   // evaluate ended fragment
    logic copy_step;   // move one payload byte
    logic commit;      // write slot bookkeeping
    logic clear;       // wipe marks and counters
    logic verify_eval; // decide verify at start
    logic scan_step;   // examine one received mark
    logic read_issue;  // issue payload read
    logic read_done;   // build read result
    logic load_out;    // result register loaded
  } rfrt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] func;
    logic       last;
    logic       frag_good;
    logic       copy_done;
    logic       scan_need;
    logic       scan_done;
    logic       out_busy;
  } rfrt_stat_t;

endpackage

@@ src/rfrt_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfrt_in_if / rfrt_out_if
// Valid/ready channels carrying the tracker's input and result items.
// ---------------------------------------------------------------------------
interface rfrt_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [7:0]        data_byte;
  logic              last_byte;
  logic signed [7:0] rssi;
  logic [7:0]        send_count;
  logic [3:0]        slot_index;
  logic [4:0]        byte_index;
  modport source (output valid, func, data_byte, last_byte, rssi, send_count,
                  slot_index, byte_index, input ready);
  modport sink (input valid, func, data_byte, last_byte, rssi, send_count,
                slot_index, byte_index, output ready);
endinterface

interface rfrt_out_if;
  logic              valid;
  logic              ready;
  logic [3:0]        status;
  logic [4:0]        request_id;
  logic              timed_out;
  logic [3:0]        fragment_total;
  logic [7:0]        read_data;
  logic [5:0]        read_length;
  logic [7:0]        read_command;
  logic              read_received;
  logic signed [7:0] last_signal;
  modport source (output valid, status, request_id, timed_out, fragment_total,
                  read_data, read_length, read_command, read_received,
                  last_signal, input ready);
  modport sink (input valid, status, request_id, timed_out, fragment_total,
                read_data, read_length, read_command, read_received,
                last_signal, output ready);
endinterface

@@ src/rfrt_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfrt_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module rfrt_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ src/rfrt_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfrt_ctrl
// Sequencer: accepts items and steps the datapath through copy, scan, read.
// ---------------------------------------------------------------------------
module rfrt_ctrl
  import rfrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  rfrt_stat_t st,
  output rfrt_cmd_t  cmd
);
  rfrt_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !st.out_busy) begin
          unique case (st.func)
            FUNC_CLEAR:  state_next = S_IDLE;
            FUNC_BYTE:   state_next = (st.last && st.frag_good) ? S_COPY : S_IDLE;
            FUNC_VERIFY: state_next = st.scan_need ? S_SCAN : S_IDLE;
            FUNC_READ:   state_next = S_READ;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_COPY: if (st.copy_done) state_next = S_IDLE;
      S_SCAN: if (st.scan_done) state_next = S_IDLE;
      S_READ: state_next = S_OUT;
      S_OUT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !st.out_busy;
        if (in_valid && !st.out_busy) begin
          cmd.take = 1'b1;
          unique case (st.func)
            FUNC_CLEAR: begin
              cmd.clear = 1'b1;
              cmd.load_out = 1'b1;
            end
            FUNC_BYTE: begin
              cmd.stage_byte = 1'b1;
              if (st.last) begin
                cmd.end_start = 1'b1;
                cmd.load_out = !st.frag_good;
              end
            end
            FUNC_VERIFY: begin
              cmd.verify_eval = 1'b1;
              cmd.load_out = !st.scan_need;
            end
            FUNC_READ: cmd.read_issue = 1'b1;
            default: ;
          endcase
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (st.copy_done) begin
          cmd.commit = 1'b1;
          cmd.load_out = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.load_out = st.scan_done;
      end
      S_READ: ;
      S_OUT: begin
        cmd.read_done = 1'b1;
        cmd.load_out = 1'b1;
      end
      default: ;
    endcase
  end
endmodule

@@ src/rfrt_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfrt_dp
// Datapath: staging buffer, slot store, bookkeeping, verify scan, result reg.
// ---------------------------------------------------------------------------
module rfrt_dp
  import rfrt_pkg::*;
#(
  parameter int FragmentSlots = DefFragmentSlots,
  parameter int PayloadBytes  = DefPayloadBytes
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  rfrt_in_if.sink    in_ch,
  rfrt_out_if.source out_ch,
  input  rfrt_cmd_t  cmd,
  output rfrt_stat_t st
);
  localparam int StageDepth = PayloadBytes + 12;
  localparam int SW  = $clog2(StageDepth + 1);
  localparam int SAW = $clog2(StageDepth);
  localparam int PW  = $clog2(PayloadBytes + 1);
  localparam int PAW = (PayloadBytes > 1) ? $clog2(PayloadBytes) : 1;
  localparam int IW  = $clog2(FragmentSlots);
  localparam int MemDepth = FragmentSlots * PayloadBytes;
  localparam int MAW = $clog2(MemDepth);

  logic [7:0] max_resend, max_retransmit;
  logic [SW-1:0] staging_count;
  logic [7:0] first_byte, id_byte;
  logic [PW-1:0] slot_length [FragmentSlots];
  logic [7:0] slot_command [FragmentSlots];
  logic [FragmentSlots-1:0] slot_received;
  logic [6:0] highest_id, final_id;
  logic [7:0] retransmit_count;
  logic signed [7:0] stored_signal;

  // captured item
  logic [3:0] sidx_q;
  logic [4:0] bidx_q;

  // fragment end evaluation on the current (last) byte
  logic [SW-1:0] len_now;
  logic [7:0] id_raw_now;
  logic [6:0] id_now;
  logic [3:0] end_status;
  always_comb begin
    len_now = (staging_count < SW'(StageDepth)) ? staging_count + SW'(1) : staging_count;
    id_raw_now = (staging_count == SW'(IdByte)) ? in_ch.data_byte : id_byte;
    id_now = id_raw_now[6:0] & IdMask[6:0];
    priority if (len_now < SW'(HdrBytes)) end_status = ST_SHORT;
    else if (len_now - SW'(HdrBytes) > SW'(PayloadBytes)) end_status = ST_LONG;
    else if (id_now == 7'd0) end_status = ST_ID_ZERO;
    else if (32'(id_now) >= FragmentSlots) end_status = ST_ID_LARGE;
    else end_status = ST_ACCEPTED;
  end

  // copy state
  logic [IW-1:0] cp_slot;
  logic [PW-1:0] cp_len, cp_k, cp_rd;
  logic cp_final, cp_rvalid;
  logic [7:0] cp_cmd;

  // staging RAM; read port used by the copy loop
  logic [SAW-1:0] stg_raddr;
  logic [7:0] stg_rdata;
  assign stg_raddr = SAW'(32'(HdrBytes) - 1 + 32'(cp_rd));
  rfrt_ram #(.Width(8), .Depth(StageDepth)) u_stage (
    .clk(clk), .we(cmd.stage_byte && staging_count < SW'(StageDepth)),
    .waddr(staging_count[SAW-1:0]), .wdata(in_ch.data_byte),
    .raddr(stg_raddr), .rdata(stg_rdata));

  // payload RAM
  logic pay_we;
  logic [MAW-1:0] pay_waddr, pay_raddr;
  logic [7:0] pay_rdata;
  assign pay_we = cmd.copy_step && cp_rvalid;
  assign pay_waddr = MAW'(32'(cp_slot) * PayloadBytes + 32'(cp_k));
  assign pay_raddr = MAW'(32'(sidx_q[IW-1:0]) * PayloadBytes
                          + 32'(bidx_q[PAW-1:0]));
  rfrt_ram #(.Width(8), .Depth(MemDepth)) u_payload (
    .clk(clk), .we(pay_we), .waddr(pay_waddr), .wdata(stg_rdata),
    .raddr(pay_raddr), .rdata(pay_rdata));

  assign st.copy_done = (cp_k == cp_len) || (cp_rvalid && cp_k + PW'(1) == cp_len);

  // scan
  logic [6:0] scan_i;
  logic [6:0] scan_lim;
  assign scan_lim = (32'(final_id) - 1 < FragmentSlots) ? final_id - 7'd1
                    : 7'(FragmentSlots);
  logic scan_hit, scan_end;
  assign scan_end = (scan_i >= scan_lim);
  assign scan_hit = !scan_end && !slot_received[scan_i[IW-1:0]];
  assign st.scan_done = scan_end || scan_hit;
  assign st.scan_need = (highest_id != 0) && (final_id != 0);

  // result register
  logic out_valid;
  logic [3:0] r_status;
  logic [4:0] r_req;
  logic r_to;
  logic [7:0] r_data, r_cmd;
  logic [5:0] r_len;
  logic r_rcv;

  // retransmit decision helper
  logic rt_ok;
  assign rt_ok = retransmit_count < max_retransmit;

  logic [3:0] n_status;
  logic [4:0] n_req;
  logic n_to, n_rcv, n_inrange;
  logic [7:0] n_data, n_cmd;
  logic [5:0] n_len;
  always_comb begin
    n_status = ST_ACK; n_req = '0; n_to = 1'b0;
    n_data = '0; n_cmd = '0; n_len = '0; n_rcv = 1'b0;
    n_inrange = 32'(sidx_q) < FragmentSlots;
    priority if (cmd.end_start || cmd.commit) begin
      n_status = cmd.commit ? ST_ACCEPTED : end_status;
    end else if (cmd.verify_eval) begin
      if (highest_id == 0) begin
        if (in_ch.send_count <= max_resend) n_status = ST_RESEND_ALL;
        else begin n_status = ST_ALL_TIMEOUT; n_to = 1'b1; end
      end else begin
        // final id unknown: ask for the one after the highest
        if (rt_ok) begin n_status = ST_RETRANSMIT; n_req = 5'(highest_id + 7'd1); end
        else begin n_status = ST_RT_TIMEOUT; n_to = 1'b1; end
      end
    end else if (cmd.scan_step) begin
      if (scan_hit) begin
        if (rt_ok) begin n_status = ST_RETRANSMIT; n_req = 5'(scan_i + 7'd1); end
        else begin n_status = ST_RT_TIMEOUT; n_to = 1'b1; end
      end else n_status = ST_OK;
    end else if (cmd.read_done) begin
      if (n_inrange) begin
        if (32'(bidx_q) < PayloadBytes) n_data = pay_rdata;
        n_len = 6'(slot_length[sidx_q[IW-1:0]]);
        n_cmd = slot_command[sidx_q[IW-1:0]];
        n_rcv = slot_received[sidx_q[IW-1:0]];
      end
    end else ;
  end

  assign st.func = in_ch.func;
  assign st.last = in_ch.last_byte;
  assign st.frag_good = (end_status == ST_ACCEPTED);
  assign st.out_busy = out_valid;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      max_resend <= 8'd3;
      max_retransmit <= 8'd5;
    end else if (cfg_we) begin
      if (cfg_index == REG_MAX_RESEND) max_resend <= cfg_data;
      else max_retransmit <= cfg_data;
    end
  end

  // staging control and captured item
  always_ff @(posedge clk) begin
    if (rst) begin
      staging_count <= '0;
      stored_signal <= '0;
    end else if (cmd.stage_byte) begin
      if (in_ch.last_byte) begin
        staging_count <= '0;
        stored_signal <= in_ch.rssi;
      end else if (staging_count < SW'(StageDepth)) begin
        staging_count <= staging_count + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sidx_q <= in_ch.slot_index;
      bidx_q <= in_ch.byte_index;
    end
    if (cmd.stage_byte && staging_count == '0) first_byte <= in_ch.data_byte;
    if (cmd.stage_byte && staging_count == SW'(IdByte)) id_byte <= in_ch.data_byte;
  end

  // copy loop: read staging one ahead, write payload
  always_ff @(posedge clk) begin
    if (rst) begin
      cp_rvalid <= 1'b0;
    end else if (cmd.end_start && st.frag_good) begin
      cp_slot <= IW'(id_now - 7'd1);
      cp_len <= PW'(len_now - SW'(HdrBytes));
      cp_final <= id_raw_now[7] & FinalBit[7];
      cp_cmd <= (staging_count == '0) ? in_ch.data_byte : first_byte;
      cp_k <= '0;
      cp_rd <= '0;
      cp_rvalid <= 1'b0;
    end else if (cmd.copy_step) begin
      cp_rd <= cp_rd + PW'(1);
      cp_rvalid <= 1'b1;
      if (cp_rvalid) cp_k <= cp_k + PW'(1);
    end
  end

  // slot bookkeeping, ids and counter
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      slot_received <= '0;
      highest_id <= '0;
      final_id <= '0;
      retransmit_count <= '0;
      for (int i = 0; i < FragmentSlots; i++) begin
        slot_length[i] <= '0;
        slot_command[i] <= '0;
      end
    end else begin
      if (cmd.commit) begin
        slot_length[cp_slot] <= cp_len;
        slot_command[cp_slot] <= cp_cmd;
        slot_received[cp_slot] <= 1'b1;
        if (7'(cp_slot) + 7'd1 > highest_id) highest_id <= 7'(cp_slot) + 7'd1;
        if (cp_final) final_id <= 7'(cp_slot) + 7'd1;
      end
      if ((cmd.verify_eval && highest_id != 0 && final_id == 0)
          || (cmd.scan_step && scan_hit))
        retransmit_count <= retransmit_count + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.verify_eval) scan_i <= '0;
    else if (cmd.scan_step && !st.scan_done) scan_i <= scan_i + 7'd1;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      r_status <= n_status; r_req <= n_req; r_to <= n_to;
      r_data <= n_data; r_len <= n_len; r_cmd <= n_cmd; r_rcv <= n_rcv;
    end
  end

  // fragment_total and last_signal track live state
  logic [6:0] ft_src;
  assign ft_src = cmd.commit && cp_final ? 7'(cp_slot) + 7'd1 : final_id;
  logic [3:0] r_ft;
  logic signed [7:0] r_sig;
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      r_ft <= cmd.clear ? 4'd0 : ft_src[3:0];
      r_sig <= (cmd.stage_byte && in_ch.last_byte) ? in_ch.rssi : stored_signal;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.status = r_status;
  assign out_ch.request_id = r_req;
  assign out_ch.timed_out = r_to;
  assign out_ch.fragment_total = r_ft;
  assign out_ch.read_data = r_data;
  assign out_ch.read_length = r_len;
  assign out_ch.read_command = r_cmd;
  assign out_ch.read_received = r_rcv;
  assign out_ch.last_signal = r_sig;
endmodule

@@ src/rf_fragment_reassembly_tracker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rf_fragment_reassembly_tracker
// Fragment reassembly and selective-repeat retransmission decisions.
// ---------------------------------------------------------------------------
// One item at a time. A non-final fragment byte, a rejected fragment end,
// clear and a verify that needs no scan (no id yet, or no final id yet) are
// handled in the idle state; a read passes through the read and output
// states; an accepted fragment runs the byte copy from staging into the
// payload RAM; a verify with a final id runs the received-mark scan. A
// finished result waits in the output register; the next item is taken once
// it has been delivered.
// ---------------------------------------------------------------------------
module rf_fragment_reassembly_tracker
  import rfrt_pkg::*;
#(
  parameter int FragmentSlots = DefFragmentSlots,
  parameter int PayloadBytes  = DefPayloadBytes
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  rfrt_in_if.sink    in_ch,
  rfrt_out_if.source out_ch
);
  rfrt_cmd_t  cmd;
  rfrt_stat_t st;
  logic rdy;

  rfrt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(rdy),
    .st(st), .cmd(cmd));

  rfrt_dp #(.FragmentSlots(FragmentSlots), .PayloadBytes(PayloadBytes)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch), .cmd(cmd), .st(st));

  assign in_ch.ready = rdy;
endmodule

@@ src/rfrt_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfrt_checker
// Port-level checks on the tracker's result channel.
// ---------------------------------------------------------------------------
module rfrt_checker
  import rfrt_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] status,
  input logic       timed_out,
  input logic [4:0] request_id
);
  // timeout flag only on timeout codes
  a_to: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (timed_out == (status == ST_ALL_TIMEOUT || status == ST_RT_TIMEOUT)))
    else $error("timed_out mismatch");
  // request id only on retransmit
  a_req: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_RETRANSMIT |-> request_id == 5'd0)
    else $error("stray request_id");
  // a held result stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped");
endmodule

bind rf_fragment_reassembly_tracker rfrt_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status), .timed_out(out_ch.timed_out),
  .request_id(out_ch.request_id));
